[src/assert_macros.svh]
// Assertion macros used by the top level of the bus enumerator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks an expression at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Checks that a condition leads to a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[src/pbe_pkg.sv]
// Types, codes and constants of the bus enumerator.
`timescale 1ns / 1ps
package pbe_pkg;

  // Request codes carried on s_tuser.
  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_RESP   = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;

  // Result kinds carried on m_tuser.
  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_FOUND  = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;
  localparam logic [1:0] KIND_LOOKUP = 2'd3;

  // Configuration address format and register offsets.
  localparam logic [31:0] CFG_ENABLE  = 32'h8000_0000;
  localparam logic [7:0]  OFS_MASK    = 8'hFC;
  localparam logic [7:0]  OFS_ID      = 8'h00;
  localparam logic [7:0]  OFS_CLASS   = 8'h08;
  localparam logic [7:0]  OFS_HDR     = 8'h0C;
  localparam logic [15:0] VENDOR_NONE = 16'hFFFF;
  localparam logic [7:0]  HDR_MULTI   = 8'h80;

  localparam logic [7:0] LAST_BUS_RESET = 8'hFF;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 104;

  // One record of the device table.
  typedef struct packed {
    logic [7:0]  bus;
    logic [4:0]  slot;
    logic [2:0]  func;
    logic [15:0] vendor;
    logic [15:0] device;
  } entry_t;

  // One result item before packing onto the master side.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [7:0]  bus;
    logic [4:0]  slot;
    logic [2:0]  func;
    logic [15:0] vendor;
    logic [15:0] id;
    logic [7:0]  cls;
    logic [7:0]  sub;
    logic        match;
    logic        last;
  } result_t;

  // Builds a lookup answer; a miss carries zeros in every device field.
  function automatic result_t make_answer(logic hit, entry_t e);
    result_t r;
    r = '0;
    r.kind = KIND_LOOKUP;
    r.last = 1'b1;
    if (hit) begin
      r.bus    = e.bus;
      r.slot   = e.slot;
      r.func   = e.func;
      r.vendor = e.vendor;
      r.id     = e.device;
      r.match  = 1'b1;
    end
    return r;
  endfunction

endpackage

[src/pbe_table.sv]
// Device table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module pbe_table #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic            clk,
  input  logic            we,
  input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] waddr,
  input  pbe_pkg::entry_t wdata,
  input  logic            re,
  input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] raddr,
  output pbe_pkg::entry_t rdata
);

  pbe_pkg::entry_t mem [TABLE_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/pbe_scan.sv]
// Scan sequencer: walks bus, slot and function and forms the read requests and result items.
`timescale 1ns / 1ps
module pbe_scan #(
  parameter int SLOTS_PER_BUS  = 32,
  parameter int FUNCS_PER_SLOT = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             resp,
  input  logic [31:0]      read_data,
  input  logic [7:0]       last_bus,
  output pbe_pkg::result_t res0,
  output pbe_pkg::result_t res1,
  output logic [1:0]       res_count,
  output logic             rec_vld,
  output pbe_pkg::entry_t  rec
);

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_ID    = 4'b0010,
    PH_CLASS = 4'b0100,
    PH_HDR   = 4'b1000
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  cur_bus, cur_bus_next;
  logic [4:0]  cur_slot, cur_slot_next;
  logic [2:0]  cur_func, cur_func_next;
  logic [31:0] held_ids, held_ids_next;

  logic             slot_wrap, scan_end, func_more;
  logic [7:0]       ns_bus;
  logic [4:0]       ns_slot;
  phase_t           ns_phase;
  pbe_pkg::result_t ns_res;
  logic [7:0]       nf_bus;
  logic [4:0]       nf_slot;
  logic [2:0]       nf_func;
  phase_t           nf_phase;
  pbe_pkg::result_t nf_res;
  pbe_pkg::result_t found_res;

  function automatic pbe_pkg::result_t read_req(logic [7:0] bus, logic [4:0] slot,
                                                logic [2:0] func, logic [7:0] ofs);
    pbe_pkg::result_t r;
    r = '0;
    r.kind = pbe_pkg::KIND_READ;
    r.addr = pbe_pkg::CFG_ENABLE | {8'h00, bus, slot, func, ofs & pbe_pkg::OFS_MASK};
    return r;
  endfunction

  // Step to function 0 of the next slot, or end the scan after the last bus.
  always_comb begin
    slot_wrap = (cur_slot == 5'(SLOTS_PER_BUS - 1));
    scan_end  = slot_wrap && (cur_bus >= last_bus);
    ns_bus    = scan_end ? 8'd0 : (slot_wrap ? cur_bus + 8'd1 : cur_bus);
    ns_slot   = slot_wrap ? 5'd0 : cur_slot + 5'd1;
    ns_phase  = scan_end ? PH_IDLE : PH_ID;
    if (scan_end) begin
      ns_res      = '0;
      ns_res.kind = pbe_pkg::KIND_DONE;
    end else begin
      ns_res = read_req(ns_bus, ns_slot, 3'd0, pbe_pkg::OFS_ID);
    end
  end

  // Step to the next function of this slot, or fall through to the next slot.
  always_comb begin
    func_more = (cur_func != 3'(FUNCS_PER_SLOT - 1));
    if (func_more) begin
      nf_bus   = cur_bus;
      nf_slot  = cur_slot;
      nf_func  = cur_func + 3'd1;
      nf_phase = PH_ID;
      nf_res   = read_req(cur_bus, cur_slot, cur_func + 3'd1, pbe_pkg::OFS_ID);
    end else begin
      nf_bus   = ns_bus;
      nf_slot  = ns_slot;
      nf_func  = 3'd0;
      nf_phase = ns_phase;
      nf_res   = ns_res;
    end
  end

  // Report of a present function once its class dword is in.
  always_comb begin
    found_res        = '0;
    found_res.kind   = pbe_pkg::KIND_FOUND;
    found_res.bus    = cur_bus;
    found_res.slot   = cur_slot;
    found_res.func   = cur_func;
    found_res.vendor = held_ids[15:0];
    found_res.id     = held_ids[31:16];
    found_res.cls    = read_data[31:24];
    found_res.sub    = read_data[23:16];
    rec.bus          = cur_bus;
    rec.slot         = cur_slot;
    rec.func         = cur_func;
    rec.vendor       = held_ids[15:0];
    rec.device       = held_ids[31:16];
  end

  // Request handling per scan phase.
  always_comb begin
    phase_next    = phase;
    cur_bus_next  = cur_bus;
    cur_slot_next = cur_slot;
    cur_func_next = cur_func;
    held_ids_next = held_ids;
    res0          = '0;
    res1          = '0;
    res_count     = 2'd0;
    rec_vld       = 1'b0;
    if (start) begin
      phase_next    = PH_ID;
      cur_bus_next  = 8'd0;
      cur_slot_next = 5'd0;
      cur_func_next = 3'd0;
      held_ids_next = 32'd0;
      res0          = read_req(8'd0, 5'd0, 3'd0, pbe_pkg::OFS_ID);
      res_count     = 2'd1;
    end else if (resp) begin
      unique case (phase)
        PH_ID: begin
          res_count = 2'd1;
          if (read_data[15:0] == pbe_pkg::VENDOR_NONE) begin
            if (cur_func == 3'd0) begin
              phase_next    = ns_phase;
              cur_bus_next  = ns_bus;
              cur_slot_next = ns_slot;
              cur_func_next = 3'd0;
              res0          = ns_res;
            end else begin
              phase_next    = nf_phase;
              cur_bus_next  = nf_bus;
              cur_slot_next = nf_slot;
              cur_func_next = nf_func;
              res0          = nf_res;
            end
          end else begin
            held_ids_next = read_data;
            phase_next    = PH_CLASS;
            res0          = read_req(cur_bus, cur_slot, cur_func, pbe_pkg::OFS_CLASS);
          end
        end
        PH_CLASS: begin
          rec_vld   = 1'b1;
          res_count = 2'd2;
          res0      = found_res;
          if (cur_func == 3'd0) begin
            phase_next = PH_HDR;
            res1       = read_req(cur_bus, cur_slot, cur_func, pbe_pkg::OFS_HDR);
          end else begin
            phase_next    = nf_phase;
            cur_bus_next  = nf_bus;
            cur_slot_next = nf_slot;
            cur_func_next = nf_func;
            res1          = nf_res;
          end
        end
        PH_HDR: begin
          res_count = 2'd1;
          if ((read_data[23:16] & pbe_pkg::HDR_MULTI) != 8'd0) begin
            phase_next    = nf_phase;
            cur_bus_next  = nf_bus;
            cur_slot_next = nf_slot;
            cur_func_next = nf_func;
            res0          = nf_res;
          end else begin
            phase_next    = ns_phase;
            cur_bus_next  = ns_bus;
            cur_slot_next = ns_slot;
            cur_func_next = 3'd0;
            res0          = ns_res;
          end
        end
        default: begin
          // A response while no scan runs is dropped.
          res_count = 2'd0;
        end
      endcase
    end
    // Mark the final result of this request.
    if (res_count == 2'd1) begin
      res0.last = 1'b1;
    end
    if (res_count == 2'd2) begin
      res1.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      cur_bus  <= 8'd0;
      cur_slot <= 5'd0;
      cur_func <= 3'd0;
      held_ids <= 32'd0;
    end else begin
      phase    <= phase_next;
      cur_bus  <= cur_bus_next;
      cur_slot <= cur_slot_next;
      cur_func <= cur_func_next;
      held_ids <= held_ids_next;
    end
  end

endmodule

[src/pbe_lookup.sv]
// Lookup walker: reads table entries in order and stops at the first match.
`timescale 1ns / 1ps
module pbe_lookup #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [15:0]      want_vendor,
  input  logic [15:0]      want_device,
  input  logic [$clog2(TABLE_DEPTH + 1)-1:0] entry_count,
  output logic             rd_en,
  output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] rd_addr,
  input  pbe_pkg::entry_t  rd_data,
  output logic             busy,
  output logic             done,
  output pbe_pkg::result_t answer
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [CW-1:0] addr;
  logic [CW-1:0] addr_inc;
  logic          cmp_vld;
  logic          cmp_last;
  logic [15:0]   want_vendor_q;
  logic [15:0]   want_device_q;
  logic          hit;

  // Compare the entry read last cycle; issue the next read alongside.
  always_comb begin
    addr_inc = addr + CW'(1);
    hit      = cmp_vld && (rd_data.vendor == want_vendor_q) &&
               (rd_data.device == want_device_q);
    done     = cmp_vld && (hit || cmp_last);
    rd_en    = busy && !done && (addr < entry_count);
    rd_addr  = addr[AW-1:0];
    answer   = pbe_pkg::make_answer(hit, rd_data);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      cmp_vld <= 1'b0;
    end else if (start) begin
      busy          <= 1'b1;
      cmp_vld       <= 1'b0;
      addr          <= '0;
      want_vendor_q <= want_vendor;
      want_device_q <= want_device;
    end else if (busy) begin
      if (done) begin
        busy    <= 1'b0;
        cmp_vld <= 1'b0;
      end else begin
        cmp_vld  <= rd_en;
        cmp_last <= (addr_inc == entry_count);
        if (rd_en) begin
          addr <= addr_inc;
        end
      end
    end
  end

endmodule

[src/pci_bus_enumerator_top.sv]
// Top level of the bus enumerator: request decode, device table and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// A start request launches a scan over buses 0 to last_bus; every step of the scan
// emits one configuration read request on the master side and waits for its
// answer as a response request on the slave side, so the scan runs at the pace of
// that external round trip. Start and response requests are worked in the cycle
// they are taken; a response that yields two results (device report plus the next
// read or the done result) holds the slave side, also while m_tready is low, until
// the second result has moved into the output register. A lookup reads the device
// table one entry per cycle from a memory with registered read data; its answer waits
// in the pending register, but an empty table is answered with a miss straight into
// the output register. One request is worked at a time, and a new request is taken
// only while the output register is empty or being emptied, so a result waiting on
// m_tready holds off the slave side. The table is kept across scans.
module pci_bus_enumerator_top #(
  parameter int TABLE_DEPTH    = 32,
  parameter int SLOTS_PER_BUS  = 32,
  parameter int FUNCS_PER_SLOT = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_wdata,   // last_bus
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,     // read_data[31:0], want_vendor[47:32], want_device[63:48]
  input  logic [1:0]   s_tuser,     // req_type[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,     // cfg_addr[31:0], dev_bus[39:32],
                                    // dev_slot[44:40], dev_func[47:45],
                                    // dev_vendor[63:48], dev_id[79:64],
                                    // class_byte[87:80], subclass_code[95:88],
                                    // match_found[96], zero[103:97]
  output logic [1:0]   m_tuser,     // result_kind[1:0]
  output logic         m_tlast      // last_result
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_PEND = 3'b100
  } state_t;

  state_t           st;
  logic [7:0]       last_bus;
  logic [CW-1:0]    entry_count;
  logic             out_vld;
  pbe_pkg::result_t out_q;
  pbe_pkg::result_t pend;

  logic             in_acc, start, resp, look, out_free, out_load;
  pbe_pkg::result_t res0, res1;
  logic [1:0]       scan_cnt;
  logic             rec_vld;
  pbe_pkg::entry_t  rec;
  logic             tbl_we, tbl_re;
  logic [AW-1:0]    tbl_raddr;
  pbe_pkg::entry_t  tbl_rdata;
  logic             lk_start, lk_busy, lk_done;
  pbe_pkg::result_t lk_res;

  // Request decode.
  always_comb begin
    out_free = !out_vld || m_tready;
    s_tready = (st == ST_IDLE) && out_free;
    in_acc   = s_tvalid && s_tready;
    start    = in_acc && (s_tuser == pbe_pkg::REQ_START);
    resp     = in_acc && (s_tuser == pbe_pkg::REQ_RESP);
    look     = in_acc && (s_tuser == pbe_pkg::REQ_LOOKUP);
    lk_start = look && (entry_count != '0);
    tbl_we   = rec_vld && (entry_count < CW'(TABLE_DEPTH));
    out_load = (scan_cnt != 2'd0) || (look && (entry_count == '0)) ||
               ((st == ST_PEND) && out_free);
  end

  pbe_scan #(
    .SLOTS_PER_BUS  (SLOTS_PER_BUS),
    .FUNCS_PER_SLOT (FUNCS_PER_SLOT)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .resp      (resp),
    .read_data (s_tdata[31:0]),
    .last_bus  (last_bus),
    .res0      (res0),
    .res1      (res1),
    .res_count (scan_cnt),
    .rec_vld   (rec_vld),
    .rec       (rec)
  );

  pbe_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (entry_count[AW-1:0]),
    .wdata (rec),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  pbe_lookup #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_lookup (
    .clk         (clk),
    .rst         (rst),
    .start       (lk_start),
    .want_vendor (s_tdata[47:32]),
    .want_device (s_tdata[63:48]),
    .entry_count (entry_count),
    .rd_en       (tbl_re),
    .rd_addr     (tbl_raddr),
    .rd_data     (tbl_rdata),
    .busy        (lk_busy),
    .done        (lk_done),
    .answer      (lk_res)
  );

  // Control, table fill count and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= ST_IDLE;
      last_bus    <= pbe_pkg::LAST_BUS_RESET;
      entry_count <= '0;
      out_vld     <= 1'b0;
    end else begin
      if (cfg_we) begin
        last_bus <= cfg_wdata;
      end
      if (tbl_we) begin
        entry_count <= entry_count + CW'(1);
      end
      if (out_load) begin
        out_vld <= 1'b1;
      end else if (m_tready) begin
        out_vld <= 1'b0;
      end
      unique case (st)
        ST_IDLE: begin
          if (scan_cnt != 2'd0) begin
            out_q <= res0;
            if (scan_cnt == 2'd2) begin
              pend <= res1;
              st   <= ST_PEND;
            end
          end
          if (look) begin
            if (entry_count == '0) begin
              out_q <= pbe_pkg::make_answer(1'b0, rec);
            end else begin
              st <= ST_LOOK;
            end
          end
        end
        ST_LOOK: begin
          if (lk_done) begin
            pend <= lk_res;
            st   <= ST_PEND;
          end
        end
        ST_PEND: begin
          if (out_free) begin
            out_q <= pend;
            st    <= ST_IDLE;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  // Master side packing.
  always_comb begin
    m_tvalid = out_vld;
    m_tuser  = out_q.kind;
    m_tlast  = out_q.last;
    m_tdata  = {7'd0, out_q.match, out_q.sub, out_q.cls, out_q.id, out_q.vendor,
                out_q.func, out_q.slot, out_q.bus, out_q.addr};
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, entry_count <= CW'(TABLE_DEPTH), "table fill count overran the table")
  `ASSERT_ALWAYS(a_no_write_in_lookup, clk, rst, !(tbl_we && lk_busy), "table written during a lookup walk")
  `ASSERT_ALWAYS(a_done_in_look, clk, rst, !lk_done || (st == ST_LOOK), "lookup finished outside the lookup state")
  `ASSERT_NEXT(a_pair_pends, clk, rst, resp && (scan_cnt == 2'd2), st == ST_PEND, "second result not held")

endmodule
